// ----- rtl/core/mer_pkg.sv -----
// Shared types and constants of the midpoint ellipse rasteriser.
`default_nettype none

package mer_pkg;

  // Depth of the command queue between the front and the engine.
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic      valid;
    cmd_kind_e kind;
  } cmd_ctl_t;

  typedef enum logic [4:0] {
    ENG_IDLE,
    ENG_SQ_A,
    ENG_SQ_B,
    ENG_INIT_AB,
    ENG_INIT_DEC,
    ENG_STEP,
    ENG_R1_AY,
    ENG_R1_BX,
    ENG_R1_CMP,
    ENG_R1_ADD,
    ENG_R1_SUB,
    ENG_R2S_TT,
    ENG_R2S_BTT,
    ENG_R2S_YY,
    ENG_R2S_AYY,
    ENG_R2S_AB,
    ENG_R2S_FIN,
    ENG_R2S_DIV,
    ENG_R2_AY,
    ENG_R2_BX,
    ENG_R2_UPD,
    ENG_EMIT
  } eng_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/mer_front.sv -----
// Request front end: classifies incoming requests and queues them for the engine.
`default_nettype none

module mer_front
  import mer_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic                         req_type_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_a_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_b_i,
  input  wire logic        [31:0]           pen_color_i,
  output cmd_ctl_t                          cmd_o,
  input  wire logic                         cmd_pop_i,
  output logic signed      [COORD_BITS-1:0] cmd_cx_o,
  output logic signed      [COORD_BITS-1:0] cmd_cy_o,
  output logic             [AXIS_BITS-1:0]  cmd_a_o,
  output logic             [AXIS_BITS-1:0]  cmd_b_o,
  output logic             [31:0]           cmd_color_o
);

  localparam int unsigned QD    = CMD_QUEUE_DEPTH;
  localparam int unsigned PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CNT_W = $clog2(QD + 1);

  cmd_kind_e                     kind_q  [QD];
  logic signed [COORD_BITS-1:0]  cx_q    [QD];
  logic signed [COORD_BITS-1:0]  cy_q    [QD];
  logic        [AXIS_BITS-1:0]   a_q     [QD];
  logic        [AXIS_BITS-1:0]   b_q     [QD];
  logic        [31:0]            color_q [QD];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;
  logic             rd_en;
  cmd_kind_e        in_kind;

  assign in_kind = (req_type_i == 1'b0) ? CMD_START : CMD_STEP;
  assign full_o  = (count_q == CNT_W'(QD));
  assign wr_en   = push_i && !full_o;
  assign rd_en   = cmd_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      kind_q[wr_ptr_q]  <= in_kind;
      cx_q[wr_ptr_q]    <= center_x_i;
      cy_q[wr_ptr_q]    <= center_y_i;
      a_q[wr_ptr_q]     <= semi_a_i;
      b_q[wr_ptr_q]     <= semi_b_i;
      color_q[wr_ptr_q] <= pen_color_i;
    end
  end

  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.kind  = kind_q[rd_ptr_q];
  assign cmd_cx_o    = cx_q[rd_ptr_q];
  assign cmd_cy_o    = cy_q[rd_ptr_q];
  assign cmd_a_o     = a_q[rd_ptr_q];
  assign cmd_b_o     = b_q[rd_ptr_q];
  assign cmd_color_o = color_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/core/mer_engine.sv -----
// Ellipse walk engine: runs the two-region midpoint walk and emits mirrored pixels.
`default_nettype none

module mer_engine
  import mer_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cmd_ctl_t                     cmd_i,
  output logic                              cmd_pop_o,
  input  wire logic signed [COORD_BITS-1:0] cmd_cx_i,
  input  wire logic signed [COORD_BITS-1:0] cmd_cy_i,
  input  wire logic        [AXIS_BITS-1:0]  cmd_a_i,
  input  wire logic        [AXIS_BITS-1:0]  cmd_b_i,
  input  wire logic        [31:0]           cmd_color_i,
  output logic                              out_valid_o,
  input  wire logic                         out_pop_i,
  output logic signed      [COORD_BITS:0]   pixel_x_o,
  output logic signed      [COORD_BITS:0]   pixel_y_o,
  output logic             [31:0]           pixel_color_o,
  output logic                              step_last_o,
  output logic                              ellipse_done_o
);

  localparam int unsigned A     = AXIS_BITS;
  localparam int unsigned SQ_W  = 2 * A;
  localparam int unsigned XW    = A + 1;
  localparam int unsigned YW    = A + 2;
  localparam int unsigned TW    = XW + 1;
  localparam int unsigned MB_W  = 2 * A + 4;
  localparam int unsigned PW    = SQ_W + MB_W;
  localparam int unsigned DEC_W = 4 * A + 8;
  localparam int unsigned PIX_W = COORD_BITS + 1;
  localparam int unsigned SUM_W = ((COORD_BITS > YW) ? COORD_BITS : YW) + 2;

  eng_state_e state_q, state_d;

  logic                  busy_q, busy_d;
  logic                  r2_q, r2_d;
  logic [1:0]            k_q, k_d;
  logic                  out_valid_q, out_valid_d;

  logic                  final_q, final_d;
  logic [XW-1:0]         x_q, x_d;
  logic signed [YW-1:0]  y_q, y_d;
  logic [XW-1:0]         ex_q, ex_d;
  logic signed [YW-1:0]  ey_q, ey_d;
  logic signed [DEC_W-1:0] dec_q, dec_d;
  logic signed [DEC_W-1:0] acc_q, acc_d;
  logic signed [DEC_W-1:0] ystep_q, ystep_d;
  logic [PW-1:0]         lhs_q, lhs_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic [SQ_W-1:0]       a2_q, a2_d;
  logic [SQ_W-1:0]       b2_q, b2_d;
  logic [A-1:0]          sa_q, sa_d;
  logic [A-1:0]          sb_q, sb_d;
  logic signed [COORD_BITS-1:0] cx_q, cx_d;
  logic signed [COORD_BITS-1:0] cy_q, cy_d;
  logic [31:0]           color_q, color_d;

  logic signed [PIX_W-1:0] pix_x_q, pix_x_d;
  logic signed [PIX_W-1:0] pix_y_q, pix_y_d;
  logic [31:0]           pix_color_q, pix_color_d;
  logic                  last_q, last_d;
  logic                  done_q, done_d;

  logic [SQ_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;
  logic                  out_free;
  logic                  r1_more;
  logic                  dec_pos;
  logic [TW-1:0]         t_val;
  logic signed [YW-1:0]  ym;
  logic signed [YW-1:0]  ym_mag;
  logic signed [DEC_W-1:0] rnd;
  logic signed [SUM_W-1:0] cxw, cyw, exw, eyw;

  assign out_free = !out_valid_q || out_pop_i;
  assign r1_more  = (lhs_q > prod_q);
  assign dec_pos  = !dec_q[DEC_W-1] && (dec_q != '0);
  assign t_val    = {x_q, 1'b1};
  assign ym       = y_q - YW'(1);
  assign ym_mag   = ym[YW-1] ? -ym : ym;
  assign rnd      = acc_q + (acc_q[DEC_W-1] ? DEC_W'(3) : DEC_W'(0));
  assign cxw      = SUM_W'(cx_q);
  assign cyw      = SUM_W'(cy_q);
  assign exw      = SUM_W'(ex_q);
  assign eyw      = SUM_W'(ey_q);

  // One shared multiplier, its product always registered.
  assign prod_d = {{MB_W{1'b0}}, mul_a} * {{SQ_W{1'b0}}, mul_b};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_i.kind == CMD_START) begin
            state_d = ENG_SQ_A;
          end else if (busy_q) begin
            state_d = ENG_STEP;
          end
        end
      end
      ENG_SQ_A:     state_d = ENG_SQ_B;
      ENG_SQ_B:     state_d = ENG_INIT_AB;
      ENG_INIT_AB:  state_d = ENG_INIT_DEC;
      ENG_INIT_DEC: state_d = ENG_STEP;
      ENG_STEP:     state_d = r2_q ? ENG_R2_AY : ENG_R1_AY;
      ENG_R1_AY:    state_d = ENG_R1_BX;
      ENG_R1_BX:    state_d = ENG_R1_CMP;
      ENG_R1_CMP:   state_d = r1_more ? ENG_R1_ADD : ENG_R2S_TT;
      ENG_R1_ADD:   state_d = ENG_R1_SUB;
      ENG_R1_SUB:   state_d = ENG_EMIT;
      ENG_R2S_TT:   state_d = ENG_R2S_BTT;
      ENG_R2S_BTT:  state_d = ENG_R2S_YY;
      ENG_R2S_YY:   state_d = ENG_R2S_AYY;
      ENG_R2S_AYY:  state_d = ENG_R2S_AB;
      ENG_R2S_AB:   state_d = ENG_R2S_FIN;
      ENG_R2S_FIN:  state_d = ENG_R2S_DIV;
      ENG_R2S_DIV:  state_d = ENG_R2_AY;
      ENG_R2_AY:    state_d = ENG_R2_BX;
      ENG_R2_BX:    state_d = ENG_R2_UPD;
      ENG_R2_UPD:   state_d = ENG_EMIT;
      ENG_EMIT: begin
        if (out_free && (k_q == 2'd3)) begin
          state_d = ENG_IDLE;
        end
      end
      default:      state_d = ENG_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    cmd_pop_o   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    busy_d      = busy_q;
    r2_d        = r2_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    final_d     = final_q;
    x_d         = x_q;
    y_d         = y_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    dec_d       = dec_q;
    acc_d       = acc_q;
    ystep_d     = ystep_q;
    lhs_d       = lhs_q;
    a2_d        = a2_q;
    b2_d        = b2_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    color_d     = color_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    pix_color_d = pix_color_q;
    last_d      = last_q;
    done_d      = done_q;

    if (out_pop_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ENG_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_START) begin
            cx_d    = cmd_cx_i;
            cy_d    = cmd_cy_i;
            color_d = cmd_color_i;
            sa_d    = cmd_a_i;
            sb_d    = cmd_b_i;
            x_d     = '0;
            y_d     = YW'(cmd_b_i);
            r2_d    = 1'b0;
            busy_d  = 1'b1;
          end
        end
      end
      ENG_SQ_A: begin
        mul_a = SQ_W'(sa_q);
        mul_b = MB_W'(sa_q);
      end
      ENG_SQ_B: begin
        a2_d  = prod_q[SQ_W-1:0];
        mul_a = SQ_W'(sb_q);
        mul_b = MB_W'(sb_q);
      end
      ENG_INIT_AB: begin
        b2_d  = prod_q[SQ_W-1:0];
        mul_a = a2_q;
        mul_b = MB_W'(sb_q);
      end
      ENG_INIT_DEC: begin
        dec_d = DEC_W'(b2_q) - DEC_W'(prod_q) + DEC_W'(a2_q >> 2);
      end
      ENG_STEP: begin
        ex_d    = x_q;
        ey_d    = y_q;
        final_d = 1'b0;
      end
      ENG_R1_AY: begin
        mul_a = a2_q;
        mul_b = MB_W'($unsigned(y_q));
      end
      ENG_R1_BX: begin
        lhs_d = prod_q;
        mul_a = b2_q;
        mul_b = MB_W'(x_q);
      end
      ENG_R1_CMP: begin
        mul_a = b2_q;
        mul_b = (MB_W'(x_q) << 1) + MB_W'(3);
      end
      ENG_R1_ADD: begin
        dec_d = dec_q + DEC_W'(prod_q);
        mul_a = a2_q;
        mul_b = (MB_W'($unsigned(y_q)) << 1) - MB_W'(2);
      end
      ENG_R1_SUB: begin
        if (!dec_q[DEC_W-1]) begin
          dec_d = dec_q - DEC_W'(prod_q);
          y_d   = y_q - YW'(1);
        end
        x_d = x_q + XW'(1);
      end
      ENG_R2S_TT: begin
        mul_a = SQ_W'(t_val);
        mul_b = MB_W'(t_val);
      end
      ENG_R2S_BTT: begin
        mul_a = b2_q;
        mul_b = prod_q[MB_W-1:0];
      end
      ENG_R2S_YY: begin
        acc_d = DEC_W'(prod_q);
        mul_a = SQ_W'($unsigned(ym_mag));
        mul_b = MB_W'($unsigned(ym_mag));
      end
      ENG_R2S_AYY: begin
        mul_a = a2_q;
        mul_b = prod_q[MB_W-1:0];
      end
      ENG_R2S_AB: begin
        acc_d = acc_q + (DEC_W'(prod_q) << 2);
        mul_a = a2_q;
        mul_b = MB_W'(b2_q);
      end
      ENG_R2S_FIN: begin
        acc_d = acc_q - (DEC_W'(prod_q) << 2);
      end
      ENG_R2S_DIV: begin
        // Adding three before the arithmetic shift rounds a negative value toward zero.
        dec_d = rnd >>> 2;
        r2_d  = 1'b1;
      end
      ENG_R2_AY: begin
        final_d = (y_q == '0);
        mul_a   = a2_q;
        mul_b   = MB_W'($unsigned(y_q));
      end
      ENG_R2_BX: begin
        ystep_d = (DEC_W'(a2_q) << 1) + DEC_W'(a2_q) - (DEC_W'(prod_q) << 1);
        mul_a   = b2_q;
        mul_b   = (MB_W'(x_q) << 1) + MB_W'(2);
      end
      ENG_R2_UPD: begin
        dec_d = dec_q + ystep_q + (dec_pos ? DEC_W'(0) : DEC_W'(prod_q));
        if (!dec_pos) begin
          x_d = x_q + XW'(1);
        end
        y_d = y_q - YW'(1);
        if (y_q == '0) begin
          busy_d = 1'b0;
        end
      end
      ENG_EMIT: begin
        if (out_free) begin
          pix_x_d     = k_q[0] ? PIX_W'(cxw - exw) : PIX_W'(cxw + exw);
          pix_y_d     = k_q[1] ? PIX_W'(cyw - eyw) : PIX_W'(cyw + eyw);
          pix_color_d = color_q;
          last_d      = (k_q == 2'd3);
          done_d      = (k_q == 2'd3) && final_q;
          out_valid_d = 1'b1;
          k_d         = k_q + 2'd1;
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      busy_q      <= 1'b0;
      r2_q        <= 1'b0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      r2_q        <= r2_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    final_q     <= final_d;
    x_q         <= x_d;
    y_q         <= y_d;
    ex_q        <= ex_d;
    ey_q        <= ey_d;
    dec_q       <= dec_d;
    acc_q       <= acc_d;
    ystep_q     <= ystep_d;
    lhs_q       <= lhs_d;
    prod_q      <= prod_d;
    a2_q        <= a2_d;
    b2_q        <= b2_d;
    sa_q        <= sa_d;
    sb_q        <= sb_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    color_q     <= color_d;
    pix_x_q     <= pix_x_d;
    pix_y_q     <= pix_y_d;
    pix_color_q <= pix_color_d;
    last_q      <= last_d;
    done_q      <= done_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign pixel_color_o  = pix_color_q;
  assign step_last_o    = last_q;
  assign ellipse_done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/midpoint_ellipse_raster_top.sv -----
// Top level of the midpoint ellipse outline rasteriser.
`default_nettype none

// This block rasterises the outline of an axis-aligned ellipse with the two-region
// midpoint algorithm. A start request (req_type_i low) loads the centre, both semi-axes
// and a colour and immediately produces the first four mirrored pixels; every step
// request (req_type_i high) produces the next four pixels, in the order (+x,+y),
// (-x,+y), (+x,-y), (-x,-y). step_last_o marks the fourth pixel of each step and
// ellipse_done_o the fourth pixel of the final step; step requests that arrive while
// no ellipse is in progress are discarded without output, and a start request always
// abandons any ellipse in progress. Pixel coordinates wrap to COORD_BITS+1 bits.
// Requests enter a two-entry command queue, so up to two transfers are taken while
// the engine is still busy, and results leave through a one-deep output register.
// All decision arithmetic runs on a single shared multiplier whose product is
// registered, so the cost of a request is set by the number of multiplier passes
// plus the pixel output phase; the step that switches regions also runs the
// region-two setup, and a start request adds squaring the axes and seeding the
// decision value. A stalled output simply lengthens the pixel phase.

module midpoint_ellipse_raster_top
  import mer_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         req_type_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_a_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_b_i,
  input  wire logic        [31:0]           pen_color_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic signed      [COORD_BITS:0]   pixel_x_o,
  output logic signed      [COORD_BITS:0]   pixel_y_o,
  output logic             [31:0]           pixel_color_o,
  output logic                              step_last_o,
  output logic                              ellipse_done_o
);

  // Head of the command queue as seen by the engine.
  cmd_ctl_t                     cmd;
  logic                         cmd_pop;
  logic signed [COORD_BITS-1:0] cmd_cx;
  logic signed [COORD_BITS-1:0] cmd_cy;
  logic        [AXIS_BITS-1:0]  cmd_a;
  logic        [AXIS_BITS-1:0]  cmd_b;
  logic        [31:0]           cmd_color;
  logic                         out_valid;

  // The front end classifies each request and holds it until the engine is free.
  mer_front #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .semi_a_i    (semi_a_i),
    .semi_b_i    (semi_b_i),
    .pen_color_i (pen_color_i),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop),
    .cmd_cx_o    (cmd_cx),
    .cmd_cy_o    (cmd_cy),
    .cmd_a_o     (cmd_a),
    .cmd_b_o     (cmd_b),
    .cmd_color_o (cmd_color)
  );

  // The engine walks the ellipse and drives the output register.
  mer_engine #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .cmd_cx_i       (cmd_cx),
    .cmd_cy_i       (cmd_cy),
    .cmd_a_i        (cmd_a),
    .cmd_b_i        (cmd_b),
    .cmd_color_i    (cmd_color),
    .out_valid_o    (out_valid),
    .out_pop_i      (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .step_last_o    (step_last_o),
    .ellipse_done_o (ellipse_done_o)
  );

  // A result is waiting whenever the output register holds one.
  assign empty = !out_valid;

endmodule

`default_nettype wire
